// ----- design/bdd_pkg.sv -----
// Shared types and constants for the binary to decimal digit converter.
// Used by the digit cells, the character emitter and the top level.

package bdd_pkg;

	localparam int unsigned VALUE_W    = 16;
	localparam int unsigned NUM_DIGITS = 5;
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned CHAR_W     = 6;
	localparam int unsigned POS_W      = $clog2(NUM_DIGITS);

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	// Place weights, most significant place first.
	localparam int unsigned PLACE_WEIGHT [NUM_DIGITS] = '{10000, 1000, 100, 10, 1};

	typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

	// Word moving down the cell chain: remainder still to convert and the
	// digits found so far (index 0 is the ten-thousands place).
	typedef struct packed {
		logic               valid;
		logic [VALUE_W-1:0] rest;
		digits_t            digits;
	} stage_t;

endpackage

// ----- design/bdd_cell.sv -----
// One place of the conversion chain: finds the digit for its place weight
// and passes the remainder on. Depends on bdd_pkg.

module bdd_cell
	import bdd_pkg::*;
#(
	parameter int unsigned IDX = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  stage_t prev,
	output stage_t next
);

	logic               valid_q;
	logic [VALUE_W-1:0] rest_q;
	digits_t            digits_q;
	logic [DIGIT_W-1:0] digit;
	logic [VALUE_W:0]   sub;
	logic [VALUE_W:0]   rest_ext;
	digits_t            digits_nxt;

	// The remainder entering a cell is below ten times its weight, so the
	// digit is the largest multiple that still fits.
	always_comb begin
		rest_ext = {1'b0, prev.rest};
		digit    = '0;
		sub      = '0;
		for (int d = 1; d <= 9; d++) begin
			if (rest_ext >= (VALUE_W+1)'(d * PLACE_WEIGHT[IDX])) begin
				digit = DIGIT_W'(d);
				sub   = (VALUE_W+1)'(d * PLACE_WEIGHT[IDX]);
			end
		end
		digits_nxt      = prev.digits;
		digits_nxt[IDX] = digit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rest_q   <= VALUE_W'(rest_ext - sub);
			digits_q <= digits_nxt;
		end
	end

	assign next = '{valid: valid_q, rest: rest_q, digits: digits_q};

endmodule

// ----- design/bdd_emit.sv -----
// Character emitter: holds one finished set of digits and sends them one
// word a cycle while out_ready is high, skipping leading zeros. Depends on bdd_pkg.

module bdd_emit
	import bdd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  stage_t            in_stage,
	output logic              take,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] digit_char,
	output logic              last
);

	logic             busy_q;
	logic [POS_W-1:0] pos_q;
	digits_t          digits_q;
	logic [POS_W-1:0] start;
	logic             load;

	// The units digit is always sent, so the search stops there.
	always_comb begin
		start = POS_W'(NUM_DIGITS - 1);
		for (int i = NUM_DIGITS - 2; i >= 0; i--) begin
			if (in_stage.digits[i] != '0) begin
				start = POS_W'(i);
			end
		end
	end

	assign last       = (pos_q == POS_W'(NUM_DIGITS - 1));
	assign out_valid  = busy_q;
	assign take       = !busy_q || (out_ready && last);
	assign load       = in_stage.valid && take;
	assign digit_char = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits_q[pos_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			pos_q  <= start;
		end else if (busy_q && out_ready) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digits_q <= in_stage.digits;
		end
	end

endmodule

// ----- design/binary_to_decimal_digits.sv -----
// Converts an unsigned 16-bit value into its decimal ASCII digits, most
// significant first, leading zeros dropped, with last set on the units digit.
// A value passes through a chain of five registered cells, one per decimal
// place, is then loaded into the emitter when the emitter can take it, and
// the emitter sends one character per cycle while out_ready is high. A value
// with more digits occupies the output longer, so the output port limits
// the sustained rate. A new value is taken while earlier ones are still in
// the chain. Depends on bdd_pkg, bdd_cell and bdd_emit.

module binary_to_decimal_digits
	import bdd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               last
);

	stage_t chain [NUM_DIGITS+1];
	logic   take;
	logic   advance;

	// The whole chain moves together whenever its tail can be handed over.
	assign advance  = !chain[NUM_DIGITS].valid || take;
	assign in_ready = advance;

	always_comb begin
		chain[0].valid  = in_valid;
		chain[0].rest   = value;
		chain[0].digits = '0;
	end

	for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
		bdd_cell #(
			.IDX(g)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (advance),
			.prev  (chain[g]),
			.next  (chain[g+1])
		);
	end

	bdd_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_stage  (chain[NUM_DIGITS]),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.digit_char(digit_char),
		.last      (last)
	);

endmodule

// ----- design/bdd_checker.sv -----
// Port-level checks for binary_to_decimal_digits, attached by bind.
// Depends on bdd_pkg.

module bdd_checker
	import bdd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [VALUE_W-1:0] value,
	input logic               out_valid,
	input logic               out_ready,
	input logic [CHAR_W-1:0]  digit_char,
	input logic               last
);

	logic run_start_q;

	// High while the next output word is the first of a run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_start_q <= 1'b1;
		end else if (out_valid && out_ready) begin
			run_start_q <= last;
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(value))
		else $error("waiting input word changed");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + 6'd9))
		else $error("digit_char outside the decimal digits");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digit_char) && $stable(last))
		else $error("stalled output word changed");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside a run of digits");

	a_no_leading_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_start_q && !last |-> digit_char != ASCII_ZERO)
		else $error("leading zero sent");

endmodule

bind binary_to_decimal_digits bdd_checker u_bdd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.value     (value),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.digit_char(digit_char),
	.last      (last)
);
